// ===== hw/rtl/mtg_pkg.sv =====
package mtg_pkg;

  // Size of the twister store and its addressing.
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = 10;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_WORDS - 1);

  // Read position codes beyond the last word.
  localparam logic [ADDR_W-1:0] POS_EMPTY    = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] POS_UNSEEDED = ADDR_W'(STATE_WORDS + 1);

  // Iteration counts of the two mixing passes of key seeding.
  localparam logic [ADDR_W-1:0] KEY_PASS1_CNT = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] KEY_PASS2_CNT = ADDR_W'(STATE_WORDS - 1);

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned KEY_LEN_W  = 3;
  localparam int unsigned KEY_REGS   = 4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET  = 3'd4;
  localparam logic [31:0] KEY_RESET [KEY_REGS] = '{32'h123, 32'h234, 32'h345, 32'h456};

  typedef enum logic [1:0] {
    OP_GENERATE = 2'd0,
    OP_SEED     = 2'd1,
    OP_KEY_SEED = 2'd2
  } op_e;

  // Generator constants.
  localparam logic [31:0] SEED_DEFAULT  = 32'd5489;
  localparam logic [31:0] KEY_BASE_SEED = 32'd19650218;
  localparam logic [31:0] INIT_MULT     = 32'd1812433253;
  localparam logic [31:0] KEY_MULT1     = 32'd1664525;
  localparam logic [31:0] KEY_MULT2     = 32'd1566083941;
  localparam logic [31:0] TWIST_MATRIX  = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT      = 32'h80000000;
  localparam logic [31:0] TEMPER_B      = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C      = 32'hefc60000;

endpackage

// ===== hw/rtl/mersenne_twister_generator.sv =====
// 32-bit MT19937 generator. A command is taken when start_i is high and busy_o
// is low; op_i selects a generate, a seed from seed_value_i, or a seed from the
// key registers. Only a generate gives a word: it appears on random_word_o for
// exactly one cycle with done_o high, and the receiver cannot hold it off, so it
// must take the word in that cycle. The 624-word state lives in one
// single-port-read, single-port-write RAM with a registered read, and every
// operation is a walk of a small sequencer over that RAM. A generate whose
// store still holds unused words reads one word from the RAM and tempers it
// into the output register. When the store is used up, the generate first
// regenerates all 624 words, with two reads and a write per word. A seed with
// a value writes the seed to word zero, then gives each further word a
// registered multiply and then a write. A key seed runs that value seed and
// then two mixing passes over the store, each word taking a RAM read with a
// registered multiply and then a write. A generate issued before any seed
// first seeds with 5489 and then regenerates, as the standard generator does.
// Key registers are to be written through the cfg port only while the block
// is idle; the block itself does not enforce this. A key_length of zero acts
// as one and a length beyond the implemented key words is cut to that number.
// The RAM holds no defined contents after reset and needs no clearing pass,
// as the block starts out unseeded.
module mersenne_twister_generator #(
  parameter int unsigned KEY_WORDS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      op_i,
  input  logic [31:0]                     seed_value_i,
  output logic                            done_o,
  output logic [31:0]                     random_word_o,
  input  logic                            cfg_we_i,
  input  logic [mtg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import mtg_pkg::*;

  // Only as many key registers are built as key seeding can ever use.
  localparam int unsigned KeyLimit = (KEY_WORDS < KEY_REGS) ? KEY_WORDS : KEY_REGS;
  localparam int unsigned JW       = (KeyLimit > 1) ? $clog2(KeyLimit) : 1;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SEED_MUL  = 4'd1;
  localparam logic [3:0] ST_SEED_WR   = 4'd2;
  localparam logic [3:0] ST_KEY_MUL   = 4'd3;
  localparam logic [3:0] ST_KEY_WR    = 4'd4;
  localparam logic [3:0] ST_KEY_WRAP  = 4'd5;
  localparam logic [3:0] ST_KEY_FINAL = 4'd6;
  localparam logic [3:0] ST_TW_RD_CUR = 4'd7;
  localparam logic [3:0] ST_TW_RD_NXT = 4'd8;
  localparam logic [3:0] ST_TW_RD_FAR = 4'd9;
  localparam logic [3:0] ST_TW_WR     = 4'd10;
  localparam logic [3:0] ST_GEN_RD    = 4'd11;
  localparam logic [3:0] ST_GEN_OUT   = 4'd12;

  // Control state.
  logic [3:0]           state_q, state_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [JW-1:0]        j_q, j_d;
  logic [KEY_LEN_W-1:0] len_q, len_d;
  logic                 phase_q, phase_d;
  logic                 gen_pend_q, gen_pend_d;
  logic                 key_mode_q, key_mode_d;
  logic                 done_q, done_d;

  // Datapath registers.
  logic [31:0] p_q, p_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] nxt_q, nxt_d;
  logic [31:0] word_q, word_d;

  // Configuration.
  logic [KEY_LEN_W-1:0] key_length_q;
  logic [31:0]          key_q [KeyLimit];
  logic [KEY_LEN_W-1:0] eff_len;

  // RAM port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  logic [31:0]       tempered;
  logic [31:0]       mix_src;
  logic [31:0]       mixed;
  logic [31:0]       new_word;
  logic [31:0]       twist_y;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W:0]   far_sum;
  logic [ADDR_W-1:0] far_addr;
  logic              key_pass_done;

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (624)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtg_temper u_temper (
    .word_i (ram_rdata),
    .word_o (tempered)
  );

  // Configuration writes; a write to a key word that is not built is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RESET;
      for (int i = 0; i < KeyLimit; i++) begin
        key_q[i] <= KEY_RESET[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_KEY_LENGTH) begin
        key_length_q <= cfg_data_i[KEY_LEN_W-1:0];
      end
      for (int i = 0; i < KeyLimit; i++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_KEY_WORD0 + i)) begin
          key_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Key length as used: zero counts as one, too many is cut to what is built.
  always_comb begin
    if (key_length_q == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length_q > KEY_LEN_W'(KeyLimit)) begin
      eff_len = KEY_LEN_W'(KeyLimit);
    end else begin
      eff_len = key_length_q;
    end
  end

  // Neighbour and far addresses of the regeneration pass, both wrapping.
  always_comb begin
    nxt_addr = (idx_q == LAST_IDX) ? '0 : idx_q + ADDR_W'(1);
    far_sum  = {1'b0, idx_q} + (ADDR_W + 1)'(TWIST_OFFSET);
    if (far_sum >= (ADDR_W + 1)'(STATE_WORDS)) begin
      far_addr = ADDR_W'(far_sum - (ADDR_W + 1)'(STATE_WORDS));
    end else begin
      far_addr = far_sum[ADDR_W-1:0];
    end
  end

  assign mix_src = p_q ^ (p_q >> 30);
  assign mixed   = ram_rdata ^ prod_q;
  assign twist_y = {cur_q[31], nxt_q[30:0]};

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    j_d           = j_q;
    len_d         = len_q;
    phase_d       = phase_q;
    gen_pend_d    = gen_pend_q;
    key_mode_d    = key_mode_q;
    done_d        = 1'b0;
    p_d           = p_q;
    prod_d        = prod_q;
    cur_d         = cur_q;
    nxt_d         = nxt_q;
    word_d        = word_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    new_word      = '0;
    key_pass_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_GENERATE: begin
              if (pos_q == POS_UNSEEDED) begin
                ram_we     = 1'b1;
                ram_wdata  = SEED_DEFAULT;
                p_d        = SEED_DEFAULT;
                idx_d      = ADDR_W'(1);
                gen_pend_d = 1'b1;
                key_mode_d = 1'b0;
                state_d    = ST_SEED_MUL;
              end else if (pos_q == POS_EMPTY) begin
                idx_d   = '0;
                state_d = ST_TW_RD_CUR;
              end else begin
                state_d = ST_GEN_RD;
              end
            end
            OP_SEED: begin
              ram_we     = 1'b1;
              ram_wdata  = seed_value_i;
              p_d        = seed_value_i;
              idx_d      = ADDR_W'(1);
              gen_pend_d = 1'b0;
              key_mode_d = 1'b0;
              state_d    = ST_SEED_MUL;
            end
            OP_KEY_SEED: begin
              ram_we     = 1'b1;
              ram_wdata  = KEY_BASE_SEED;
              p_d        = KEY_BASE_SEED;
              idx_d      = ADDR_W'(1);
              gen_pend_d = 1'b0;
              key_mode_d = 1'b1;
              len_d      = eff_len;
              state_d    = ST_SEED_MUL;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEED_MUL: begin
        prod_d  = INIT_MULT * mix_src;
        state_d = ST_SEED_WR;
      end

      ST_SEED_WR: begin
        new_word  = prod_q + 32'(idx_q);
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_word;
        p_d       = new_word;
        if (idx_q == LAST_IDX) begin
          if (key_mode_q) begin
            // The first mixing step works on index one, so its predecessor
            // is word zero, which still holds the base seed.
            p_d     = KEY_BASE_SEED;
            idx_d   = ADDR_W'(1);
            j_d     = '0;
            cnt_d   = KEY_PASS1_CNT;
            phase_d = 1'b0;
            state_d = ST_KEY_MUL;
          end else if (gen_pend_q) begin
            pos_d   = POS_EMPTY;
            idx_d   = '0;
            state_d = ST_TW_RD_CUR;
          end else begin
            pos_d   = POS_EMPTY;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          state_d = ST_SEED_MUL;
        end
      end

      ST_KEY_MUL: begin
        ram_raddr = idx_q;
        prod_d    = (phase_q ? KEY_MULT2 : KEY_MULT1) * mix_src;
        state_d   = ST_KEY_WR;
      end

      ST_KEY_WR: begin
        if (phase_q) begin
          new_word = mixed - 32'(idx_q);
        end else begin
          new_word = mixed + key_q[j_q] + 32'(j_q);
        end
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_word;
        p_d       = new_word;
        cnt_d     = cnt_q - ADDR_W'(1);
        if (!phase_q) begin
          j_d = (KEY_LEN_W'(j_q) + KEY_LEN_W'(1) >= len_q) ? '0 : JW'(j_q + 1'b1);
        end
        if (idx_q == LAST_IDX) begin
          idx_d   = ADDR_W'(1);
          state_d = ST_KEY_WRAP;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
          if (cnt_q == ADDR_W'(1)) begin
            key_pass_done = 1'b1;
          end else begin
            state_d = ST_KEY_MUL;
          end
        end
      end

      // The first word follows the last one each time the index wraps.
      ST_KEY_WRAP: begin
        ram_we    = 1'b1;
        ram_wdata = p_q;
        if (cnt_q == '0) begin
          key_pass_done = 1'b1;
        end else begin
          state_d = ST_KEY_MUL;
        end
      end

      ST_KEY_FINAL: begin
        ram_we    = 1'b1;
        ram_wdata = HIGH_BIT;
        pos_d     = POS_EMPTY;
        state_d   = ST_IDLE;
      end

      ST_TW_RD_CUR: begin
        ram_raddr = '0;
        state_d   = ST_TW_RD_NXT;
      end

      // The word being replaced is only read for the first index; after that
      // it is the neighbour read on the previous step.
      ST_TW_RD_NXT: begin
        ram_raddr = nxt_addr;
        if (idx_q == '0) begin
          cur_d = ram_rdata;
        end
        state_d = ST_TW_RD_FAR;
      end

      ST_TW_RD_FAR: begin
        ram_raddr = far_addr;
        nxt_d     = ram_rdata;
        state_d   = ST_TW_WR;
      end

      ST_TW_WR: begin
        new_word  = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_word;
        cur_d     = nxt_q;
        if (idx_q == LAST_IDX) begin
          pos_d   = '0;
          state_d = ST_GEN_RD;
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          state_d = ST_TW_RD_NXT;
        end
      end

      ST_GEN_RD: begin
        ram_raddr = pos_q;
        pos_d     = pos_q + ADDR_W'(1);
        state_d   = ST_GEN_OUT;
      end

      ST_GEN_OUT: begin
        word_d  = tempered;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // End of a mixing pass: the first pass hands over to the second, the
    // second closes with the fixed top word.
    if (key_pass_done) begin
      if (!phase_q) begin
        phase_d = 1'b1;
        cnt_d   = KEY_PASS2_CNT;
        state_d = ST_KEY_MUL;
      end else begin
        state_d = ST_KEY_FINAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= POS_UNSEEDED;
      idx_q      <= '0;
      cnt_q      <= '0;
      j_q        <= '0;
      len_q      <= KEY_LEN_RESET;
      phase_q    <= 1'b0;
      gen_pend_q <= 1'b0;
      key_mode_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      j_q        <= j_d;
      len_q      <= len_d;
      phase_q    <= phase_d;
      gen_pend_q <= gen_pend_d;
      key_mode_q <= key_mode_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    word_q <= word_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign random_word_o = word_q;

endmodule

// ===== hw/rtl/mtg_ram.sv =====
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mtg_temper.sv =====
module mtg_temper (
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);
  import mtg_pkg::*;

  logic [31:0] y1, y2, y3;

  // Standard tempering: two right shifts and two masked left shifts.
  always_comb begin
    y1     = word_i ^ (word_i >> 11);
    y2     = y1 ^ ((y1 << 7) & TEMPER_B);
    y3     = y2 ^ ((y2 << 15) & TEMPER_C);
    word_o = y3 ^ (y3 >> 18);
  end

endmodule
